// ===== design/rgbc_pkg.sv =====
`default_nettype none
package rgbc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ROW_LIMIT     = 1024;

  // channel sum: nine 8u x 8s taps fit in 20 signed bits
  localparam int SUM_W = 20;
  localparam int MAG_W = SUM_W - 1;
  localparam int DIV_W = 16;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] col_out;
    logic [9:0] row_out;
    logic       frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4,
    REG_DIVISOR      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q_r;
    logic [7:0] q_g;
    logic [7:0] q_b;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rgb_conv3x3_filter_unit.sv =====
// 3x3 convolution over an RGB pixel stream.
// Input channel: in_valid/in_stall with in_item (pixel plus flush bit).
// Pixels arrive in raster order; after the frame, flush items drain the
// last row plus one result. Output channel: out_valid/out_stall with
// out_item (filtered pixel, position, frame_end). Results lag one row
// plus one pixel of input.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, ready always high.
// The user must write it only while idle; the block does not enforce this.
// Flow: one item at a time. An item without a result goes through a
// line store read, then the write-back. An item with a result also
// passes its nine taps through one multiply-accumulate per channel,
// then a 19-step restoring divider runs the three channels.
// The finished result sits in an output register; the next item is taken
// while it waits. If the receiver stalls, a second result waits in a hold
// register and the input stalls until the output register frees.
// Reset: counters, window and output valid clear; registers take their
// defaults. Line store contents are undefined until written and are only
// read for taps outside the frame.
`default_nettype none
module rgb_conv3x3_filter_unit
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WID_W > 11) ? WID_W : 11;
  localparam int ROW_W = 11;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MAC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [10:0]      frame_width, frame_height;
  logic [23:0]      coef_top_row, coef_mid_row, coef_bot_row;
  logic [DIV_W-1:0] divisor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd1024;
      frame_height <= 11'd1024;
      coef_top_row <= 24'd0;
      coef_mid_row <= 24'd256;
      coef_bot_row <= 24'd0;
      divisor      <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[10:0];
        REG_COEF_TOP:     coef_top_row <= cfg_data;
        REG_COEF_MID:     coef_mid_row <= cfg_data;
        REG_COEF_BOT:     coef_bot_row <= cfg_data;
        REG_DIVISOR:      divisor      <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CMP_W-1:0] w;
  logic [ROW_W-1:0] h;

  always_comb begin
    if (frame_width == '0)
      w = CMP_W'(1);
    else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH))
      w = CMP_W'(MAX_WIDTH);
    else
      w = CMP_W'(frame_width);
    if (frame_height == '0)
      h = ROW_W'(1);
    else if (frame_height > ROW_W'(ROW_LIMIT))
      h = ROW_W'(ROW_LIMIT);
    else
      h = frame_height;
  end

  // input counters and per-item latches
  logic [COL_W-1:0] in_col, c;
  logic [ROW_W-1:0] in_row, r;
  logic [23:0]      px;
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;
  logic             draining, ignore, accept;

  always_comb begin
    if (CMP_W'(in_col) >= w || {1'b0, in_row} > ({1'b0, h} + 12'd1)) begin
      col_eff = '0;
      row_eff = '0;
    end else begin
      col_eff = in_col;
      row_eff = in_row;
    end
    draining = row_eff >= h;
    ignore   = !draining && in_item.flush;
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // line stores: entry holds {two rows above, row above}
  logic [47:0]      mem [MAX_WIDTH];
  logic [47:0]      rd_data;
  logic             mem_we;
  logic [47:0]      mem_wdata;

  always_ff @(posedge clk) begin
    if (accept && !ignore) rd_data <= mem[col_eff];
    if (mem_we) mem[c] <= mem_wdata;
  end

  // window and result position
  logic [23:0]      win      [9];
  logic [23:0]      win_calc [9];
  logic [23:0]      shifted  [9];
  logic [23:0]      restart  [9];
  logic [23:0]      top, mid;
  logic             have, last;
  logic [ROW_W-1:0] tr, tr_c;
  logic [COL_W-1:0] tc, tc_c;
  logic             last_q;

  assign top       = rd_data[47:24];
  assign mid       = rd_data[23:0];
  assign mem_we    = (state == ST_RD);
  assign mem_wdata = {mid, px};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i*3]   = win[i*3+1];
      shifted[i*3+1] = win[i*3+2];
    end
    shifted[2] = (c == '0) ? 24'd0 : top;
    shifted[5] = (c == '0) ? 24'd0 : mid;
    shifted[8] = (c == '0) ? 24'd0 : px;
    // window seen by the next item at a row start
    for (int k = 0; k < 9; k++) restart[k] = 24'd0;
    restart[2] = top;
    restart[5] = mid;
    restart[8] = px;
    have = 1'b0;
    tr_c = '0;
    tc_c = '0;
    if (c == '0) begin
      if (r >= ROW_W'(2)) begin
        have = 1'b1;
        tr_c = r - ROW_W'(2);
        tc_c = COL_W'(w - CMP_W'(1));
      end
    end else if (r >= ROW_W'(1)) begin
      have = 1'b1;
      tr_c = r - ROW_W'(1);
      tc_c = c - COL_W'(1);
    end
    last = have && (tr_c == h - ROW_W'(1)) && (CMP_W'(tc_c) == w - CMP_W'(1));
  end

  // tap walk
  logic [1:0]              ti, tj;
  logic                    tap_ok;
  logic [23:0]             tap_px;
  logic [23:0]             wrow;
  logic signed [7:0]       wt;
  logic signed [16:0]      prod [3];
  logic signed [SUM_W-1:0] acc  [3];

  always_comb begin
    unique case (ti)
      2'd0:    wrow = coef_top_row;
      2'd1:    wrow = coef_mid_row;
      default: wrow = coef_bot_row;
    endcase
    unique case (tj)
      2'd0:    wt = wrow[7:0];
      2'd1:    wt = wrow[15:8];
      default: wt = wrow[23:16];
    endcase
    tap_px = win_calc[ti*3 + tj];
    tap_ok = (ti != 2'd0 || tr != '0) &&
             (ti != 2'd2 || (tr + ROW_W'(1)) < h) &&
             (tj != 2'd0 || tc != '0) &&
             (tj != 2'd2 || (CMP_W'(tc) + CMP_W'(1)) < w);
    for (int k = 0; k < 3; k++)
      prod[k] = $signed({1'b0, tap_px[k*8 +: 8]}) * wt;
  end

  // divider
  div_req_t dreq;
  div_rsp_t drsp;
  logic     rsp_ready;

  assign dreq.start = (state == ST_MAC) && ti == 2'd2 && tj == 2'd2;
  assign dreq.sum_r = acc[0] + (tap_ok ? SUM_W'(prod[0]) : '0);
  assign dreq.sum_g = acc[1] + (tap_ok ? SUM_W'(prod[1]) : '0);
  assign dreq.sum_b = acc[2] + (tap_ok ? SUM_W'(prod[2]) : '0);

  rgbc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (dreq),
    .divisor (divisor),
    .rsp     (drsp)
  );

  // hold divider result until the output register frees
  logic [7:0] q_r, q_g, q_b;

  always_ff @(posedge clk) begin
    if (drsp.done) begin
      q_r <= drsp.q_r;
      q_g <= drsp.q_g;
      q_b <= drsp.q_b;
    end
  end

  assign rsp_ready = !out_valid || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else begin
      if (state == ST_OUT && rsp_ready) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            in_col <= col_eff;
            in_row <= row_eff;
            if (!ignore) begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          for (int k = 0; k < 9; k++) win[k] <= (c == '0) ? restart[k] : shifted[k];
          if (last || CMP_W'(c) + CMP_W'(1) >= w) begin
            in_col <= '0;
            in_row <= last ? '0 : r + ROW_W'(1);
          end else begin
            in_col <= c + COL_W'(1);
          end
          state <= have ? ST_MAC : ST_IDLE;
        end
        ST_MAC: begin
          if (ti == 2'd2 && tj == 2'd2) state <= ST_DIV;
        end
        ST_DIV: begin
          if (drsp.done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-item payload, tap counters and sums
  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      c  <= col_eff;
      r  <= row_eff;
      px <= draining ? 24'd0
                     : {in_item.blue_in, in_item.green_in, in_item.red_in};
    end
    if (state == ST_RD) begin
      for (int k = 0; k < 9; k++) win_calc[k] <= shifted[k];
      tr     <= tr_c;
      tc     <= tc_c;
      last_q <= last;
      ti     <= 2'd0;
      tj     <= 2'd0;
      for (int k = 0; k < 3; k++) acc[k] <= '0;
    end else if (state == ST_MAC) begin
      for (int k = 0; k < 3; k++)
        if (tap_ok) acc[k] <= acc[k] + SUM_W'(prod[k]);
      if (tj == 2'd2) begin
        tj <= 2'd0;
        ti <= ti + 2'd1;
      end else begin
        tj <= tj + 2'd1;
      end
    end
    if (state == ST_OUT && rsp_ready) begin
      out_item.red_out   <= q_r;
      out_item.green_out <= q_g;
      out_item.blue_out  <= q_b;
      out_item.col_out   <= 10'(tc);
      out_item.row_out   <= tr[9:0];
      out_item.frame_end <= last_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/rgbc_div.sv =====
`default_nettype none
module rgbc_div
  import rgbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  input  wire logic [DIV_W-1:0] divisor,
  output div_rsp_t              rsp
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [DIV_W-1:0] dvs;
  logic [2:0]       neg;
  logic [DIV_W:0]   rem  [3];
  logic [MAG_W-1:0] quo  [3];
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic signed [SUM_W-1:0] sums [3];
  logic [DIV_W:0]   rem_sh [3];
  logic             ge     [3];
  logic [7:0]       qlo    [3];

  assign sums[0] = req.sum_r;
  assign sums[1] = req.sum_g;
  assign sums[2] = req.sum_b;

  // one restoring step per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem[k][DIV_W-1:0], quo[k][MAG_W-1]};
      ge[k]     = rem_sh[k] >= {1'b0, dvs};
      qlo[k]    = neg[k] ? (~quo[k][7:0] + 8'd1) : quo[k][7:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath: load magnitudes, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= (divisor == '0) ? DIV_W'(1) : divisor;
      for (int k = 0; k < 3; k++) begin
        neg[k] <= sums[k][SUM_W-1];
        rem[k] <= '0;
        quo[k] <= sums[k][SUM_W-1] ? MAG_W'(-sums[k]) : MAG_W'(sums[k]);
      end
    end else if (busy) begin
      for (int k = 0; k < 3; k++) begin
        rem[k] <= ge[k] ? (rem_sh[k] - {1'b0, dvs}) : rem_sh[k];
        quo[k] <= {quo[k][MAG_W-2:0], ge[k]};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q_r  = qlo[0];
  assign rsp.q_g  = qlo[1];
  assign rsp.q_b  = qlo[2];

endmodule
`default_nettype wire
